// ===== src/bms_pkg.sv =====
// Shared types, codes and the melody note table of the buzzer melody sequencer.
package bms_pkg;

    // Number of melodies that start requests may select.
    localparam int MELODY_COUNT = 5;
    // Number of melodies that the note table actually holds.
    localparam int TABLE_MELODIES = 5;

    // Depth of the sequencer state memory; only entry zero is used.
    localparam int STATE_DEPTH = 2;
    localparam int STATE_AW = $clog2(STATE_DEPTH);

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // Melody numbers.
    localparam logic [2:0] MEL_CLICK   = 3'd0;
    localparam logic [2:0] MEL_BEEP    = 3'd1;
    localparam logic [2:0] MEL_SUCCESS = 3'd2;
    localparam logic [2:0] MEL_ERROR   = 3'd3;
    localparam logic [2:0] MEL_ALARM   = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_ENABLE     = 3'd0;
    localparam logic [2:0] REG_CLICK_FREQ = 3'd1;
    localparam logic [2:0] REG_CLICK_DUR  = 3'd2;
    localparam logic [2:0] REG_BEEP_FREQ  = 3'd3;
    localparam logic [2:0] REG_BEEP_DUR   = 3'd4;
    localparam logic [2:0] REG_ALARM_LOW  = 3'd5;
    localparam logic [2:0] REG_ALARM_HIGH = 3'd6;

    // Configuration register file.
    typedef struct packed {
        logic        enable;
        logic [15:0] click_freq;
        logic [15:0] click_dur;
        logic [15:0] beep_freq;
        logic [15:0] beep_dur;
        logic [15:0] alarm_low_freq;
        logic [15:0] alarm_high_freq;
    } t_cfg;

    // Sequencer state record kept in the state memory. All zero is the idle state.
    typedef struct packed {
        logic        active;
        logic [2:0]  melody;
        logic [2:0]  position;
        logic [15:0] elapsed_ms;
    } t_state;

    // One note of a melody.
    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] dur;
    } t_note;

    // Number of notes in a melody; zero for a number without a melody.
    function automatic logic [2:0] melody_length(input logic [2:0] mel);
        logic [2:0] len;
        case (mel)
            MEL_CLICK:   len = 3'd1;
            MEL_BEEP:    len = 3'd3;
            MEL_SUCCESS: len = 3'd3;
            MEL_ERROR:   len = 3'd2;
            MEL_ALARM:   len = 3'd5;
            default:     len = 3'd0;
        endcase
        return len;
    endfunction

    // Frequency and duration of a note, with the programmable notes taken from cfg.
    function automatic t_note note_of(input logic [2:0] mel, input logic [2:0] pos,
                                      input t_cfg cfg);
        t_note n;
        n = '0;
        case (mel)
            MEL_CLICK: begin
                n.freq = cfg.click_freq;
                n.dur  = cfg.click_dur;
            end
            MEL_BEEP: begin
                if (pos == 3'd1) begin
                    n.freq = 16'd0;
                    n.dur  = 16'd50;
                end else begin
                    n.freq = cfg.beep_freq;
                    n.dur  = cfg.beep_dur;
                end
            end
            MEL_SUCCESS: begin
                if (pos == 3'd0) begin
                    n.freq = 16'd1000;
                    n.dur  = 16'd80;
                end else if (pos == 3'd1) begin
                    n.freq = 16'd1500;
                    n.dur  = 16'd80;
                end else begin
                    n.freq = 16'd2000;
                    n.dur  = 16'd120;
                end
            end
            MEL_ERROR: begin
                if (pos == 3'd0) begin
                    n.freq = 16'd500;
                    n.dur  = 16'd150;
                end else begin
                    n.freq = 16'd300;
                    n.dur  = 16'd200;
                end
            end
            MEL_ALARM: begin
                if (pos >= 3'd4) begin
                    n.freq = 16'd0;
                    n.dur  = 16'd400;
                end else if (pos[0] == 1'b0) begin
                    n.freq = cfg.alarm_low_freq;
                    n.dur  = 16'd200;
                end else begin
                    n.freq = cfg.alarm_high_freq;
                    n.dur  = 16'd200;
                end
            end
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage

// ===== src/bms_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module bms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; returns the old contents on a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/buzzer_melody_sequencer_core.sv =====
// Top level of the buzzer melody sequencer: handshakes, registers and state update.
//
// The sequencer takes one transaction per clock on its input stream: a one-millisecond
// tick, a start of one of five melodies (click, beep, success, error, alarm) or a stop.
// Every input transaction yields exactly one output transaction that carries the tone
// frequency to drive (0 in a rest or when idle), the playing flag and the current note
// index, with tlast set on the tick that ends a melody. The sequencer state lives in one
// entry of a small synchronous RAM: it is read as a transaction is accepted, updated while
// the item sits in stage one and written back as it moves on to the output register, and
// a write that lands on the same edge as the next read is forwarded, so items follow each
// other with no gap while the output is taken. The output register decouples the two sides,
// and the input side stalls only while that register is full and not being taken. The state entry
// needs no clearing pass; a single valid flag makes it read as idle after reset.
// Configuration writes are accepted in any cycle and take effect on the next item.
module buzzer_melody_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [2:0] melody_select, [7:3] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] op
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [15:0] tone_freq, [16] playing, [19:17] note_index,
                                     // [23:20] zero
    output logic        o_m_tlast,   // finished
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import bms_pkg::*;

    localparam logic [STATE_AW-1:0] STATE_ADDR = '0;

    // Configuration registers.
    t_cfg r_cfg;

    // Stage one: the accepted item while its state read completes.
    logic        r_s1_valid;
    logic [1:0]  r_s1_op;
    logic [2:0]  r_s1_sel;

    // Forwarding of a write-back that coincides with the read of the next item.
    logic        r_fwd_hit;
    t_state      r_last_wr;
    logic        r_state_written;

    // Output register.
    logic        r_out_valid;
    logic [15:0] r_out_freq;
    logic        r_out_playing;
    logic [2:0]  r_out_index;
    logic        r_out_finished;

    logic        in_accept;
    logic        s1_advance;
    logic        ram_we;
    t_state      ram_rdata;
    t_state      cur_state;
    t_state      n_state;
    t_note       cur_note;
    t_note       new_note;
    logic        n_finished;
    logic [15:0] elapsed_inc;
    logic [2:0]  pos_inc;

    // Handshakes.
    assign s1_advance  = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_s1_valid || s1_advance;
    assign in_accept   = i_s_tvalid && o_s_tready;
    assign ram_we      = s1_advance;
    assign o_cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable          <= 1'b1;
            r_cfg.click_freq      <= 16'd4000;
            r_cfg.click_dur       <= 16'd10;
            r_cfg.beep_freq       <= 16'd2000;
            r_cfg.beep_dur        <= 16'd100;
            r_cfg.alarm_low_freq  <= 16'd800;
            r_cfg.alarm_high_freq <= 16'd1600;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ENABLE:     r_cfg.enable          <= i_cfg_data[0];
                REG_CLICK_FREQ: r_cfg.click_freq      <= i_cfg_data;
                REG_CLICK_DUR:  r_cfg.click_dur       <= i_cfg_data;
                REG_BEEP_FREQ:  r_cfg.beep_freq       <= i_cfg_data;
                REG_BEEP_DUR:   r_cfg.beep_dur        <= i_cfg_data;
                REG_ALARM_LOW:  r_cfg.alarm_low_freq  <= i_cfg_data;
                REG_ALARM_HIGH: r_cfg.alarm_high_freq <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // State memory: read on accept, written back as stage one moves on.
    bms_ram #(
        .WIDTH ($bits(t_state)),
        .DEPTH (STATE_DEPTH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (STATE_ADDR),
        .i_wdata (n_state),
        .i_re    (in_accept),
        .i_raddr (STATE_ADDR),
        .o_rdata (ram_rdata)
    );

    // Stage one control and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op   <= i_s_tuser;
            r_s1_sel  <= i_s_tdata[2:0];
            r_fwd_hit <= ram_we;
        end
    end

    // Copy of the last write-back and the flag that the entry holds valid data.
    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_last_wr <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_written <= 1'b0;
        end else if (ram_we) begin
            r_state_written <= 1'b1;
        end
    end

    // Current state: forwarded write, memory contents, or idle after reset.
    always_comb begin
        if (r_fwd_hit) begin
            cur_state = r_last_wr;
        end else if (r_state_written) begin
            cur_state = ram_rdata;
        end else begin
            cur_state = '0;
        end
    end

    assign elapsed_inc = (cur_state.elapsed_ms == 16'hFFFF) ? cur_state.elapsed_ms
                                                            : cur_state.elapsed_ms + 16'd1;
    assign pos_inc     = cur_state.position + 3'd1;
    assign cur_note    = note_of(cur_state.melody, cur_state.position, r_cfg);

    // State update for the item in stage one.
    always_comb begin
        n_state    = cur_state;
        n_finished = 1'b0;
        case (r_s1_op)
            OP_TICK: begin
                if (cur_state.active) begin
                    n_state.elapsed_ms = elapsed_inc;
                    if (elapsed_inc >= cur_note.dur) begin
                        n_state.position   = pos_inc;
                        n_state.elapsed_ms = 16'd0;
                        if (pos_inc >= melody_length(cur_state.melody)) begin
                            n_state.active   = 1'b0;
                            n_state.position = 3'd0;
                            n_finished       = 1'b1;
                        end
                    end
                end
            end
            OP_START: begin
                if (r_cfg.enable && ({1'b0, r_s1_sel} < 4'(MELODY_COUNT))
                    && ({1'b0, r_s1_sel} < 4'(TABLE_MELODIES))) begin
                    n_state.active     = 1'b1;
                    n_state.melody     = r_s1_sel;
                    n_state.position   = 3'd0;
                    n_state.elapsed_ms = 16'd0;
                end
            end
            OP_STOP: begin
                n_state.active   = 1'b0;
                n_state.position = 3'd0;
            end
            default: begin
            end
        endcase
    end

    assign new_note = note_of(n_state.melody, n_state.position, r_cfg);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_freq     <= n_state.active ? new_note.freq : 16'd0;
            r_out_playing  <= n_state.active;
            r_out_index    <= n_state.active ? n_state.position : 3'd0;
            r_out_finished <= n_finished;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_index, r_out_playing, r_out_freq};
    assign o_m_tlast  = r_out_finished;

`ifndef SYNTH
    // An accepted item is always in stage one on the next cycle.
    a_accept_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted item did not reach stage one");

    // The ending tick of a melody reports an idle, silent block.
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_finished) |-> (!r_out_playing && r_out_freq == 16'd0))
        else $error("finished result still reports a tone");

    // An idle result always carries note index zero.
    a_idle_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_playing) |-> (r_out_index == 3'd0))
        else $error("idle result with nonzero note index");

    // A stalled output register keeps stage one from writing back.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !ram_we)
        else $error("state written back while output stalled");

    // A write-back on the edge of a new read must be forwarded to that item.
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && ram_we) |=> (r_fwd_hit && r_last_wr == $past(n_state)))
        else $error("coinciding write-back not forwarded");
`endif

endmodule
